// ===== design/sbpf_pkg.sv =====
// Package for the servo bus packet framer: action and result codes, packet
// constants and the state and result word structs. No dependencies.
`default_nettype none
package sbpf_pkg;

  typedef enum logic [2:0] {
    ACT_WRITE = 3'd0,
    ACT_READ  = 3'd1,
    ACT_PING  = 3'd2,
    ACT_RESET = 3'd3,
    ACT_RX    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_READ = 2'd1,
    KIND_PING = 2'd2,
    KIND_REJ  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_RD1  = 2'd1,
    PEND_RD2  = 2'd2,
    PEND_PING = 2'd3
  } pend_t;

  localparam int unsigned PKT_MAX = 9;

  localparam logic [7:0] HDR_BYTE    = 8'hFF;
  localparam logic [7:0] INS_PING    = 8'h01;
  localparam logic [7:0] INS_READ    = 8'h02;
  localparam logic [7:0] INS_WRITE   = 8'h03;
  localparam logic [7:0] INS_RESET   = 8'h06;
  localparam logic [7:0] ID_REG_ADDR = 8'd3;
  localparam logic [7:0] BAD_ID_A    = 8'd253;
  localparam logic [7:0] BAD_ID_B    = 8'd255;
  localparam logic [7:0] LEN_SHORT   = 8'd2;
  localparam logic [7:0] LEN_READ    = 8'd4;
  localparam logic [7:0] LEN_WR_BASE = 8'd3;
  localparam logic [7:0] ID_RESET    = 8'd1;

  localparam logic [3:0] PKT_N_SHORT = 4'd6;
  localparam logic [3:0] PKT_N_READ  = 4'd8;
  localparam logic [3:0] PKT_N_WBASE = 4'd7;

  localparam logic [3:0] RX_N_RD1  = 4'd7;
  localparam logic [3:0] RX_N_RD2  = 4'd8;
  localparam logic [3:0] RX_N_PING = 4'd6;
  localparam logic [3:0] RX_IDX_ID = 4'd2;
  localparam logic [3:0] RX_IDX_LO = 4'd5;
  localparam logic [3:0] RX_IDX_HI = 4'd6;

  localparam logic REG_START_ID   = 1'b0;
  localparam logic REG_FACTORY_ID = 1'b1;

  typedef struct packed {
    logic [7:0] current_id;
    pend_t      pending;
    logic [3:0] rx_count;
    logic [7:0] rx_sum;
    logic [7:0] rx_id;
    logic [7:0] rx_lo;
    logic [7:0] rx_hi;
  } state_t;

  typedef struct packed {
    logic [PKT_MAX-1:0][7:0] bytes;
    logic [3:0]              count;
    kind_t                   kind;
    logic [15:0]             value;
    logic                    ok;
  } res_t;

endpackage
`default_nettype wire

// ===== design/sbpf_build.sv =====
// Single-pass command decode: builds the whole packet or reply result for
// one input word and the next framer state. Depends on sbpf_pkg.
`default_nettype none
module sbpf_build (
  input  var sbpf_pkg::state_t  st,
  input  wire logic [7:0]       factory_id,
  input  var sbpf_pkg::action_t action,
  input  wire logic [7:0]       reg_addr,
  input  wire logic [1:0]       data_len,
  input  wire logic [15:0]      data_word,
  input  wire logic [7:0]       rx_byte,
  output var sbpf_pkg::state_t  st_nxt,
  output var sbpf_pkg::res_t    res
);

  logic [sbpf_pkg::PKT_MAX-1:0][7:0] body;
  logic [3:0] n;
  logic [3:0] last_idx;
  logic [7:0] sum;
  logic [7:0] lo;
  logic       len_ok;
  logic       is_tx;
  logic       reject;
  logic [3:0] rx_size;
  logic       rx_final;

  assign lo       = data_word[7:0];
  assign len_ok   = (data_len == 2'd1) || (data_len == 2'd2);
  assign last_idx = n - 4'd1;
  assign sum      = body[2] + body[3] + body[4] + body[5] + body[6] + body[7];

  always_comb begin
    case (st.pending)
      sbpf_pkg::PEND_RD1: rx_size = sbpf_pkg::RX_N_RD1;
      sbpf_pkg::PEND_RD2: rx_size = sbpf_pkg::RX_N_RD2;
      default:            rx_size = sbpf_pkg::RX_N_PING;
    endcase
  end

  assign rx_final = (st.rx_count + 4'd1) >= rx_size;

  always_comb begin
    st_nxt  = st;
    body    = '0;
    body[0] = sbpf_pkg::HDR_BYTE;
    body[1] = sbpf_pkg::HDR_BYTE;
    body[2] = st.current_id;
    n       = '0;
    is_tx   = 1'b0;
    reject  = 1'b0;
    res       = '0;
    res.kind  = sbpf_pkg::KIND_TX;
    case (action)
      sbpf_pkg::ACT_WRITE: begin
        if (!len_ok || ((reg_addr == sbpf_pkg::ID_REG_ADDR) &&
            ((lo == sbpf_pkg::BAD_ID_A) || (lo == sbpf_pkg::BAD_ID_B)))) begin
          reject = 1'b1;
        end else begin
          is_tx           = 1'b1;
          st_nxt.pending  = sbpf_pkg::PEND_NONE;
          st_nxt.rx_count = '0;
          st_nxt.rx_sum   = '0;
          body[3] = sbpf_pkg::LEN_WR_BASE + {6'd0, data_len};
          body[4] = sbpf_pkg::INS_WRITE;
          body[5] = reg_addr;
          body[6] = lo;
          if (data_len == 2'd2) begin
            body[7] = data_word[15:8];
          end
          n = sbpf_pkg::PKT_N_WBASE + {2'd0, data_len};
          if (reg_addr == sbpf_pkg::ID_REG_ADDR) begin
            st_nxt.current_id = lo;
          end
        end
      end
      sbpf_pkg::ACT_READ: begin
        if (!len_ok) begin
          reject = 1'b1;
        end else begin
          is_tx           = 1'b1;
          st_nxt.rx_count = '0;
          st_nxt.rx_sum   = '0;
          st_nxt.pending  = sbpf_pkg::pend_t'(data_len);
          body[3] = sbpf_pkg::LEN_READ;
          body[4] = sbpf_pkg::INS_READ;
          body[5] = reg_addr;
          body[6] = {6'd0, data_len};
          n = sbpf_pkg::PKT_N_READ;
        end
      end
      sbpf_pkg::ACT_PING: begin
        is_tx           = 1'b1;
        st_nxt.rx_count = '0;
        st_nxt.rx_sum   = '0;
        st_nxt.pending  = sbpf_pkg::PEND_PING;
        body[3] = sbpf_pkg::LEN_SHORT;
        body[4] = sbpf_pkg::INS_PING;
        n = sbpf_pkg::PKT_N_SHORT;
      end
      sbpf_pkg::ACT_RESET: begin
        is_tx             = 1'b1;
        st_nxt.rx_count   = '0;
        st_nxt.rx_sum     = '0;
        st_nxt.pending    = sbpf_pkg::PEND_NONE;
        st_nxt.current_id = factory_id;
        body[3] = sbpf_pkg::LEN_SHORT;
        body[4] = sbpf_pkg::INS_RESET;
        n = sbpf_pkg::PKT_N_SHORT;
      end
      sbpf_pkg::ACT_RX: begin
        if (st.pending != sbpf_pkg::PEND_NONE) begin
          if (st.rx_count == sbpf_pkg::RX_IDX_ID) begin
            st_nxt.rx_id = rx_byte;
          end
          if ((st.rx_count == sbpf_pkg::RX_IDX_LO) &&
              (st.pending != sbpf_pkg::PEND_PING)) begin
            st_nxt.rx_lo = rx_byte;
          end
          if ((st.rx_count == sbpf_pkg::RX_IDX_HI) &&
              (st.pending == sbpf_pkg::PEND_RD2)) begin
            st_nxt.rx_hi = rx_byte;
          end
          if ((st.rx_count >= sbpf_pkg::RX_IDX_ID) &&
              (st.rx_count < (rx_size - 4'd1))) begin
            st_nxt.rx_sum = st.rx_sum + rx_byte;
          end
          if (rx_final) begin
            res.count = 4'd1;
            if (st.pending == sbpf_pkg::PEND_PING) begin
              res.kind  = sbpf_pkg::KIND_PING;
              res.value = {8'd0, st_nxt.rx_id};
            end else begin
              res.kind  = sbpf_pkg::KIND_READ;
              res.value = {(st.pending == sbpf_pkg::PEND_RD2) ? st_nxt.rx_hi : 8'd0,
                           st_nxt.rx_lo};
              res.ok    = (~st.rx_sum == rx_byte);
            end
            st_nxt.pending  = sbpf_pkg::PEND_NONE;
            st_nxt.rx_count = '0;
            st_nxt.rx_sum   = '0;
          end else begin
            st_nxt.rx_count = st.rx_count + 4'd1;
          end
        end
      end
      default: begin
        reject = 1'b1;
      end
    endcase

    if (reject) begin
      res.count = 4'd1;
      res.kind  = sbpf_pkg::KIND_REJ;
    end
    if (is_tx) begin
      res.count = n;
      res.kind  = sbpf_pkg::KIND_TX;
      for (int i = 0; i < sbpf_pkg::PKT_MAX; i++) begin
        res.bytes[i] = (4'(i) == last_idx) ? ~sum : body[i];
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/sbpf_emit.sv =====
// Result register: holds one built packet or reply result and shifts it out
// one word per handshake. Depends on sbpf_pkg.
`default_nettype none
module sbpf_emit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  var sbpf_pkg::res_t  res,
  output logic                can_load,
  output logic                out_valid,
  input  wire logic           out_ready,
  output sbpf_pkg::kind_t     out_kind,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic [15:0]         out_value,
  output logic                out_ok
);

  logic [sbpf_pkg::PKT_MAX-1:0][7:0] bytes_r;
  logic [sbpf_pkg::PKT_MAX-1:0][7:0] bytes_nxt;
  logic [3:0]                        count_r;
  logic [3:0]                        count_nxt;
  sbpf_pkg::kind_t                   kind_r;
  logic [15:0]                       value_r;
  logic                              ok_r;

  assign out_valid = (count_r != 4'd0);
  assign can_load  = (count_r == 4'd0) || ((count_r == 4'd1) && out_ready);

  always_comb begin
    bytes_nxt = bytes_r;
    count_nxt = count_r;
    if (load) begin
      bytes_nxt = res.bytes;
      count_nxt = res.count;
    end else if (out_valid && out_ready) begin
      bytes_nxt = {8'd0, bytes_r[sbpf_pkg::PKT_MAX-1:1]};
      count_nxt = count_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    if (load) begin
      kind_r  <= res.kind;
      value_r <= res.value;
      ok_r    <= res.ok;
    end
  end

  assign out_kind  = kind_r;
  assign out_byte  = (kind_r == sbpf_pkg::KIND_TX) ? bytes_r[0] : 8'd0;
  assign out_last  = (kind_r == sbpf_pkg::KIND_TX) && (count_r == 4'd1);
  assign out_value = value_r;
  assign out_ok    = ok_r;

endmodule
`default_nettype wire

// ===== design/servo_bus_packet_framer_top.sv =====
// Latency: the first result word is valid the cycle after the command word.
// Throughput: a packet of n bytes (6 to 9) leaves at one word per cycle while
// out_tready is high; the next command is taken in the cycle its last word leaves.
// Reply bytes and rejected commands are taken whenever the result register can load.
// Reset (rst_n low, synchronous): id and default id 1, no reply awaited.
// Top level of the servo bus packet framer; uses sbpf_pkg, sbpf_build, sbpf_emit.
`default_nettype none
module servo_bus_packet_framer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] reg_addr, [9:8] data_len, [25:10] data_word, [33:26] rx_byte
  input  wire logic [39:0] in_tdata,
  // [2:0] action
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] tx_byte, [23:8] read_value, [24] checksum_ok
  output logic [31:0]      out_tdata,
  // [1:0] kind
  output logic [1:0]       out_tuser,
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  sbpf_pkg::state_t st_r;
  sbpf_pkg::state_t st_nxt;
  sbpf_pkg::res_t   res;
  sbpf_pkg::kind_t  out_kind;
  logic [7:0]       factory_id_r;
  logic             in_fire;
  logic             cfg_fire;
  logic [7:0]       out_byte;
  logic [15:0]      out_value;
  logic             out_ok;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  sbpf_build u_build (
    .st         (st_r),
    .factory_id (factory_id_r),
    .action     (sbpf_pkg::action_t'(in_tuser)),
    .reg_addr   (in_tdata[7:0]),
    .data_len   (in_tdata[9:8]),
    .data_word  (in_tdata[25:10]),
    .rx_byte    (in_tdata[33:26]),
    .st_nxt     (st_nxt),
    .res        (res)
  );

  sbpf_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .res       (res),
    .can_load  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_tlast),
    .out_value (out_value),
    .out_ok    (out_ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.current_id <= sbpf_pkg::ID_RESET;
      st_r.pending    <= sbpf_pkg::PEND_NONE;
      st_r.rx_count   <= '0;
      st_r.rx_sum     <= '0;
      st_r.rx_id      <= '0;
      st_r.rx_lo      <= '0;
      st_r.rx_hi      <= '0;
      factory_id_r    <= sbpf_pkg::ID_RESET;
    end else begin
      if (in_fire) begin
        st_r <= st_nxt;
      end else if (cfg_fire && (cfg_index == sbpf_pkg::REG_START_ID)) begin
        st_r.current_id <= cfg_data;
      end
      if (cfg_fire && (cfg_index == sbpf_pkg::REG_FACTORY_ID)) begin
        factory_id_r <= cfg_data;
      end
    end
  end

  assign out_tdata = {7'd0, out_ok, out_value, out_byte};
  assign out_tuser = out_kind;

endmodule
`default_nettype wire

// ===== design/sbpf_check.sv =====
// Port-level checker for the servo bus packet framer, bound to the top level.
// Depends on sbpf_pkg and servo_bus_packet_framer_top.
`default_nettype none
module sbpf_check (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [2:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  a_last_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == sbpf_pkg::KIND_TX)
    else $error("last flag on a non-transmit word");

  a_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != sbpf_pkg::KIND_TX) |-> out_tdata[7:0] == 8'd0)
    else $error("packet byte on a non-transmit word");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid || out_tready)
    else $error("input taken while result register is blocked");

  a_unknown_rej: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[2] && (in_tuser[1:0] != 2'd0))
    |=> out_tvalid && (out_tuser == sbpf_pkg::KIND_REJ))
    else $error("unknown action not rejected");

endmodule

bind servo_bus_packet_framer_top sbpf_check u_sbpf_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
